// ----- src/pnf_pkg.sv -----
// Shared constants, codes and control structs for the Petri net fire engine.
package pnf_pkg;

    localparam int DEF_MAX_PLACES = 16;
    localparam int DEF_MAX_TRANS  = 16;
    localparam int DEF_TOKEN_BITS = 16;

    localparam int WEIGHT_W = 16;
    localparam int COUNT_W  = 5;

    localparam logic [COUNT_W-1:0] COUNT_RST = 5'd16;
    localparam logic [COUNT_W-1:0] LIST_CAP  = 5'd16;

    // request action codes
    localparam logic [2:0] ACT_WR_IN  = 3'd0;
    localparam logic [2:0] ACT_WR_OUT = 3'd1;
    localparam logic [2:0] ACT_WR_TOK = 3'd2;
    localparam logic [2:0] ACT_LIST   = 3'd3;
    localparam logic [2:0] ACT_FIRE   = 3'd4;

    // configuration register indexes
    localparam logic CFG_PLACES = 1'b0;
    localparam logic CFG_TRANS  = 1'b1;

    typedef struct packed {
        logic       clr;
        logic       wr_iw;
        logic       wr_ow;
        logic       wr_tok;
        logic       ld;
        logic       en;
        logic       fired;
        logic       last;
        logic [3:0] idx;
    } t_cmd;

    typedef struct packed {
        logic               covered;
        logic               out_free;
        logic [COUNT_W-1:0] act_trans;
        logic [COUNT_W-1:0] list_n;
    } t_stat;

endpackage

// ----- src/pnf_req_if.sv -----
// Request channel: one action with place, transition and value.
interface pnf_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [3:0]  place;
    logic [3:0]  transition;
    logic [15:0] value;

    modport source (output valid, action, place, transition, value, input ready);
    modport sink   (input valid, action, place, transition, value, output ready);
endinterface

// ----- src/pnf_rsp_if.sv -----
// Result channel: one per-transition report.
interface pnf_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] trans_index;
    logic       enabled;
    logic       fired;
    logic       saturated;
    logic       last;

    modport source (output valid, trans_index, enabled, fired, saturated, last, input ready);
    modport sink   (input valid, trans_index, enabled, fired, saturated, last, output ready);
endinterface

// ----- src/pnf_ctrl.sv -----
// Controller: clearing sweep, request decode, list walk and fire sequencing.
module pnf_ctrl #(
    parameter int MAX_TRANS = pnf_pkg::DEF_MAX_TRANS,
    parameter int TA_W      = 4,
    parameter int CNT_W     = 5
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [2:0]      i_action,
    input  logic [3:0]      i_transition,
    input  pnf_pkg::t_stat  i_stat,
    output pnf_pkg::t_cmd   o_cmd,
    output logic [TA_W-1:0] o_rd_addr
);
    import pnf_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LIST  = 2'd2;
    localparam logic [1:0] ST_FIRE  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [3:0]       r_trans, n_trans;
    logic             accept;
    logic [6:0]       cnt7;
    logic [6:0]       ntr7;
    logic [6:0]       ncnt7;
    logic             fire_ok;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;
    assign cnt7    = 7'(r_cnt);
    assign fire_ok = (7'(r_trans) < 7'(i_stat.act_trans)) && i_stat.covered;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_trans = r_trans;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (r_cnt == CNT_W'(MAX_TRANS - 1)) begin
                    n_state = ST_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_action)
                        ACT_WR_IN:  o_cmd.wr_iw  = 1'b1;
                        ACT_WR_OUT: o_cmd.wr_ow  = 1'b1;
                        ACT_WR_TOK: o_cmd.wr_tok = 1'b1;
                        ACT_LIST: begin
                            if (i_stat.list_n != '0) begin
                                n_state = ST_LIST;
                                n_cnt   = '0;
                            end
                        end
                        ACT_FIRE: begin
                            n_trans = i_transition;
                            n_state = ST_FIRE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LIST: begin
                if (i_stat.out_free) begin
                    o_cmd.ld   = 1'b1;
                    o_cmd.idx  = cnt7[3:0];
                    o_cmd.en   = i_stat.covered;
                    o_cmd.last = (cnt7 + 7'd1) == 7'(i_stat.list_n);
                    if (o_cmd.last) begin
                        n_state = ST_IDLE;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            ST_FIRE: begin
                if (i_stat.out_free) begin
                    o_cmd.ld    = 1'b1;
                    o_cmd.idx   = r_trans;
                    o_cmd.en    = fire_ok;
                    o_cmd.fired = fire_ok;
                    o_cmd.last  = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // read the row that the next cycle evaluates; during the sweep, the row being cleared
    assign ntr7  = 7'(n_trans);
    assign ncnt7 = 7'(n_cnt);
    always_comb begin
        if (r_state == ST_CLEAR) begin
            o_rd_addr = cnt7[TA_W-1:0];
        end else if (n_state == ST_FIRE) begin
            o_rd_addr = ntr7[TA_W-1:0];
        end else begin
            o_rd_addr = ncnt7[TA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
            r_trans <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_trans <= n_trans;
        end
    end

endmodule

// ----- src/pnf_dp.sv -----
// Datapath: per-place weight memories, token registers, config and result register.
module pnf_dp #(
    parameter int MAX_PLACES = pnf_pkg::DEF_MAX_PLACES,
    parameter int MAX_TRANS  = pnf_pkg::DEF_MAX_TRANS,
    parameter int TOKEN_BITS = pnf_pkg::DEF_TOKEN_BITS,
    parameter int TA_W       = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [pnf_pkg::COUNT_W-1:0] i_cfg_data,
    input  logic [3:0]                  i_place,
    input  logic [3:0]                  i_transition,
    input  logic [15:0]                 i_value,
    input  pnf_pkg::t_cmd               i_cmd,
    input  logic [TA_W-1:0]             i_rd_addr,
    output pnf_pkg::t_stat              o_stat,
    pnf_rsp_if.source                   o_rsp
);
    import pnf_pkg::*;

    localparam logic [33:0] TOK_MAX = (34'd1 << TOKEN_BITS) - 34'd1;

    logic [COUNT_W-1:0]    r_piu, r_tiu;
    logic [6:0]            place7, trans7, act7;
    logic                  trans_ok;
    logic [TA_W-1:0]       wr_addr;
    logic [WEIGHT_W-1:0]   wr_data;
    logic [33:0]           val34, tok34;
    logic [TOKEN_BITS-1:0] tok_wr;
    logic                  commit;
    logic [MAX_PLACES-1:0] lane_ok, lane_sat;

    logic       r_ov;
    logic [3:0] r_idx;
    logic       r_en, r_fired, r_sat, r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_piu <= COUNT_RST;
            r_tiu <= COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PLACES: r_piu <= i_cfg_data;
                CFG_TRANS:  r_tiu <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign place7   = 7'(i_place);
    assign trans7   = 7'(i_transition);
    assign trans_ok = trans7 < 7'(MAX_TRANS);
    assign wr_addr  = i_cmd.clr ? i_rd_addr : trans7[TA_W-1:0];
    assign wr_data  = i_cmd.clr ? '0 : i_value;
    assign val34    = 34'(i_value);
    assign tok34    = (val34 > TOK_MAX) ? TOK_MAX : val34;
    assign tok_wr   = tok34[TOKEN_BITS-1:0];
    assign commit   = i_cmd.ld && i_cmd.fired;

    for (genvar gp = 0; gp < MAX_PLACES; gp++) begin : g_lane
        logic [WEIGHT_W-1:0]   r_iw_mem [MAX_TRANS];
        logic [WEIGHT_W-1:0]   r_ow_mem [MAX_TRANS];
        logic [WEIGHT_W-1:0]   r_iw_q, r_ow_q;
        logic [TOKEN_BITS-1:0] r_tok;
        logic                  hit, active, sat;
        logic [33:0]           sum;
        logic [TOKEN_BITS-1:0] n_tok;

        assign hit    = (place7 == 7'(gp));
        assign active = 7'(gp) < 7'(r_piu);

        always_ff @(posedge i_clk) begin
            if (i_cmd.clr || (i_cmd.wr_iw && hit && trans_ok)) begin
                r_iw_mem[wr_addr] <= wr_data;
            end
            if (i_cmd.clr || (i_cmd.wr_ow && hit && trans_ok)) begin
                r_ow_mem[wr_addr] <= wr_data;
            end
            r_iw_q <= r_iw_mem[i_rd_addr];
            r_ow_q <= r_ow_mem[i_rd_addr];
        end

        // only used when enabled, so tokens >= input weight
        assign sum   = 34'(r_tok) - 34'(r_iw_q) + 34'(r_ow_q);
        assign sat   = sum > TOK_MAX;
        assign n_tok = sat ? TOK_MAX[TOKEN_BITS-1:0] : sum[TOKEN_BITS-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tok <= '0;
            end else if (i_cmd.wr_tok && hit) begin
                r_tok <= tok_wr;
            end else if (commit && active) begin
                r_tok <= n_tok;
            end
        end

        assign lane_ok[gp]  = !active || (34'(r_tok) >= 34'(r_iw_q));
        assign lane_sat[gp] = active && sat;
    end

    assign act7 = (7'(r_tiu) > 7'(MAX_TRANS)) ? 7'(MAX_TRANS) : 7'(r_tiu);

    always_comb begin
        o_stat           = '0;
        o_stat.covered   = &lane_ok;
        o_stat.out_free  = !r_ov || o_rsp.ready;
        o_stat.act_trans = act7[COUNT_W-1:0];
        o_stat.list_n    = (act7[COUNT_W-1:0] > LIST_CAP) ? LIST_CAP : act7[COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.ld) begin
            r_ov <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld) begin
            r_idx   <= i_cmd.idx;
            r_en    <= i_cmd.en;
            r_fired <= i_cmd.fired;
            r_sat   <= i_cmd.fired && (|lane_sat);
            r_last  <= i_cmd.last;
        end
    end

    assign o_rsp.valid       = r_ov;
    assign o_rsp.trans_index = r_idx;
    assign o_rsp.enabled     = r_en;
    assign o_rsp.fired       = r_fired;
    assign o_rsp.saturated   = r_sat;
    assign o_rsp.last        = r_last;

endmodule

// ----- src/petri_net_fire_engine_top.sv -----
// Petri net fire engine: arc weight stores, marking, list and fire.
// A write is stored at the edge on which it is accepted. A list request walks one transition per
// cycle from a registered row read while the output is free; a fire request loads its single
// result from a registered row read. A waiting result stalls the walk, and the next request is
// taken once the last result is loaded. One request is in work at a time. Reset: synchronous,
// active low; tokens go to zero and both counts to 16, then a sweep zeroes the weight memories.
module petri_net_fire_engine_top #(
    parameter int MAX_PLACES      = pnf_pkg::DEF_MAX_PLACES,
    parameter int MAX_TRANSITIONS = pnf_pkg::DEF_MAX_TRANS,
    parameter int TOKEN_BITS      = pnf_pkg::DEF_TOKEN_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [pnf_pkg::COUNT_W-1:0] i_cfg_data,
    pnf_req_if.sink                     i_req,
    pnf_rsp_if.source                   o_rsp
);
    import pnf_pkg::*;

    localparam int TA_W  = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
    localparam int CNT_W = $clog2(MAX_TRANSITIONS + 1);

    t_cmd            w_cmd;
    t_stat           w_stat;
    logic [TA_W-1:0] w_rd_addr;

    pnf_ctrl #(
        .MAX_TRANS (MAX_TRANSITIONS),
        .TA_W      (TA_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_req.valid),
        .o_ready      (i_req.ready),
        .i_action     (i_req.action),
        .i_transition (i_req.transition),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd),
        .o_rd_addr    (w_rd_addr)
    );

    pnf_dp #(
        .MAX_PLACES (MAX_PLACES),
        .MAX_TRANS  (MAX_TRANSITIONS),
        .TOKEN_BITS (TOKEN_BITS),
        .TA_W       (TA_W)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_place      (i_req.place),
        .i_transition (i_req.transition),
        .i_value      (i_req.value),
        .i_cmd        (w_cmd),
        .i_rd_addr    (w_rd_addr),
        .o_stat       (w_stat),
        .o_rsp        (o_rsp)
    );

    // a result is never loaded over one still waiting
    a_ld_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ld |-> w_stat.out_free)
        else $error("result loaded while output register busy");

    // no request taken during the clearing sweep
    a_clr_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr |-> !i_req.ready)
        else $error("request accepted during clear");

    a_fired_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.fired) |-> (o_rsp.enabled && o_rsp.last))
        else $error("fired result not enabled or not last");

    a_sat_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.saturated) |-> o_rsp.fired)
        else $error("saturation without fire");

endmodule

// ----- tb/sv/petri_net_fire_engine_top_tb.sv -----
// Self-checking testbench for the Petri net fire engine: directed and random requests.
module petri_net_fire_engine_top_tb;
    import pnf_pkg::*;

    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
    localparam int          N_NODES        = 16;
    localparam logic [15:0] TOKEN_FULL     = 16'hFFFF;
    localparam int          STALL_LIMIT    = 5000;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          HOLDOFF_CYCLES = 300;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  place;
        logic [3:0]  transition;
        logic [15:0] value;
    } net_req_t;

    typedef struct packed {
        logic [3:0] trans_index;
        logic       enabled;
        logic       fired;
        logic       saturated;
        logic       last;
    } net_report_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [COUNT_W-1:0] i_cfg_data;

    pnf_req_if req_if ();
    pnf_rsp_if rsp_if ();

    petri_net_fire_engine_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    // mirror of the net: weights indexed [transition][place]
    logic [15:0]        pre_w   [N_NODES][N_NODES];
    logic [15:0]        post_w  [N_NODES][N_NODES];
    logic [15:0]        marking [N_NODES];
    logic [COUNT_W-1:0] places_cfg;
    logic [COUNT_W-1:0] trans_cfg;

    net_req_t    request_backlog[$];
    net_report_t expected_reports[$];
    net_req_t    on_bus;

    int send_idle_pct;
    int recv_stall_pct;
    int holdoff_request;
    int holdoff_left;
    int idle_cycles;
    int n_err;
    int n_reports;
    int n_lists;
    int n_fires;
    int n_fired;
    int n_clipped;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int live_places();
        return (places_cfg > N_NODES) ? N_NODES : int'(places_cfg);
    endfunction

    function automatic int live_trans();
        return (trans_cfg > N_NODES) ? N_NODES : int'(trans_cfg);
    endfunction

    function automatic bit marking_covers(int t);
        for (int p = 0; p < live_places(); p++)
            if (marking[p] < pre_w[t][p]) return 1'b0;
        return 1'b1;
    endfunction

    // update the mirrored net for one accepted request and queue its reports
    function automatic void apply_to_net(net_req_t r);
        int          nt;
        int          np;
        logic [16:0] next_count;
        bit          en;
        bit          clip;
        net_report_t rep;
        nt = live_trans();
        np = live_places();
        case (r.action)
            ACT_WR_IN:  pre_w[r.transition][r.place] = r.value;
            ACT_WR_OUT: post_w[r.transition][r.place] = r.value;
            ACT_WR_TOK: marking[r.place] = r.value;
            ACT_LIST: begin
                n_lists++;
                for (int i = 0; i < nt; i++) begin
                    rep.trans_index = 4'(i);
                    rep.enabled     = marking_covers(i);
                    rep.fired       = 1'b0;
                    rep.saturated   = 1'b0;
                    rep.last        = (i == nt - 1);
                    expected_reports.push_back(rep);
                end
            end
            ACT_FIRE: begin
                n_fires++;
                en   = (int'(r.transition) < nt) && marking_covers(r.transition);
                clip = 1'b0;
                if (en) begin
                    for (int q = 0; q < np; q++) begin
                        next_count = {1'b0, marking[q]} - pre_w[r.transition][q]
                                     + post_w[r.transition][q];
                        if (next_count > TOKEN_FULL) begin
                            next_count = TOKEN_FULL;
                            clip       = 1'b1;
                        end
                        marking[q] = next_count[15:0];
                    end
                    n_fired++;
                    if (clip) n_clipped++;
                end
                rep = '{r.transition, en, en, clip, 1'b1};
                expected_reports.push_back(rep);
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            n_err++;
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) apply_to_net(on_bus);
            if (!req_if.valid || req_if.ready) begin
                if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = request_backlog.pop_front();
                    req_if.valid      <= 1'b1;
                    req_if.action     <= on_bus.action;
                    req_if.place      <= on_bus.place;
                    req_if.transition <= on_bus.transition;
                    req_if.value      <= on_bus.value;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // report monitor and receiver backpressure
    always @(posedge i_clk) begin
        net_report_t want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                n_reports++;
                if (expected_reports.size() == 0) begin
                    $error("unexpected report: trans_index=%0d enabled=%0d fired=%0d",
                           rsp_if.trans_index, rsp_if.enabled, rsp_if.fired);
                    n_err++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("trans_index", want.trans_index, rsp_if.trans_index);
                    check_field("enabled", want.enabled, rsp_if.enabled);
                    check_field("fired", want.fired, rsp_if.fired);
                    check_field("saturated", want.saturated, rsp_if.saturated);
                    check_field("last", want.last, rsp_if.last);
                end
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                rsp_if.ready <= 1'b0;
            end else if (holdoff_request > 0) begin
                holdoff_left    = holdoff_request;
                holdoff_request = 0;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog: outstanding work with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (request_backlog.size() == 0 && expected_reports.size() == 0 && !req_if.valid))
        begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $error("no handshake for %0d cycles, %0d reports outstanding",
                   idle_cycles, expected_reports.size());
            $display("petri_net_fire_engine_top regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic void queue_req(logic [2:0] action, logic [3:0] place,
                                      logic [3:0] transition, logic [15:0] value);
        request_backlog.push_back('{action, place, transition, value});
    endfunction

    function automatic logic [3:0] pick_index(int n_use);
        if ($urandom_range(9) == 0) return 4'($urandom_range(15));
        return 4'($urandom_range(n_use - 1));
    endfunction

    // small weights and token counts dominate so that fires often succeed
    function automatic net_req_t random_request();
        net_req_t r;
        int       roll;
        int       np;
        int       nt;
        np = live_places();
        nt = live_trans();
        if (np == 0) np = N_NODES;
        if (nt == 0) nt = N_NODES;
        r.place      = pick_index(np);
        r.transition = pick_index(nt);
        r.value      = 16'($urandom);
        roll = $urandom_range(99);
        if (roll < 25) begin
            r.action = $urandom_range(1) ? ACT_WR_OUT : ACT_WR_IN;
            if ($urandom_range(9) < 7) r.value = 16'($urandom_range(4));
        end else if (roll < 42) begin
            r.action = ACT_WR_TOK;
            roll = $urandom_range(9);
            if (roll < 7) r.value = 16'($urandom_range(12));
            else if (roll < 9) r.value = TOKEN_FULL - 16'($urandom_range(3));
        end else if (roll < 57) begin
            r.action = ACT_LIST;
        end else if (roll < 92) begin
            r.action = ACT_FIRE;
        end else begin
            r.action = 3'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
        end
        return r;
    endfunction

    task automatic write_reg(logic idx, logic [COUNT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_PLACES) places_cfg = data;
        else trans_cfg = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (request_backlog.size() != 0 || req_if.valid || expected_reports.size() != 0);
        // writes leave no report behind, give the last one time to land
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(logic [COUNT_W-1:0] np, logic [COUNT_W-1:0] nt,
                             idle_mode_e mode, int n_items, int holdoff);
        write_reg(CFG_PLACES, np);
        write_reg(CFG_TRANS, nt);
        @(negedge i_clk);
        send_idle_pct   = (mode == IDLE_SEND) ? 87 : (mode == IDLE_BOTH) ? 34 : 0;
        recv_stall_pct  = (mode == IDLE_RECV) ? 87 : (mode == IDLE_BOTH) ? 34 : 0;
        holdoff_request = holdoff;
        repeat (n_items) request_backlog.push_back(random_request());
        wait_idle();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_PLACES;
        i_cfg_data        = '0;
        req_if.valid      = 1'b0;
        req_if.action     = ACT_WR_IN;
        req_if.place      = '0;
        req_if.transition = '0;
        req_if.value      = '0;
        rsp_if.ready      = 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        holdoff_request   = 0;
        holdoff_left      = 0;
        places_cfg        = COUNT_RST;
        trans_cfg         = COUNT_RST;
        foreach (pre_w[t, p]) begin
            pre_w[t][p]  = '0;
            post_w[t][p] = '0;
        end
        foreach (marking[p]) marking[p] = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part on the reset configuration, empty net first
        queue_req(ACT_LIST, 4'd0, 4'd0, 16'd0);
        queue_req(ACT_FIRE, 4'd0, 4'd0, 16'd0);          // fires with no count change
        queue_req(ACT_WR_TOK, 4'd0, 4'd0, TOKEN_FULL);
        queue_req(ACT_WR_TOK, 4'd15, 4'd0, 16'd3);
        queue_req(ACT_WR_IN, 4'd15, 4'd1, 16'd4);
        queue_req(ACT_FIRE, 4'd0, 4'd1, 16'd0);          // short one token
        queue_req(ACT_WR_IN, 4'd0, 4'd2, 16'd1);
        queue_req(ACT_WR_OUT, 4'd0, 4'd2, TOKEN_FULL);
        queue_req(ACT_FIRE, 4'd0, 4'd2, 16'd0);          // clips at full
        queue_req(ACT_WR_OUT, 4'd15, 4'd15, TOKEN_FULL);
        queue_req(ACT_FIRE, 4'd0, 4'd15, 16'd0);         // clips on last place
        queue_req(ACT_WR_IN, 4'd15, 4'd3, TOKEN_FULL);
        queue_req(ACT_FIRE, 4'd0, 4'd3, 16'd0);          // exact cover drains to zero
        queue_req(ACT_LIST, 4'd0, 4'd0, 16'd0);
        queue_req(ACT_WR_TOK, 4'd7, 4'd0, 16'h5A5A);
        queue_req(ACT_WR_TOK, 4'd8, 4'd0, 16'hA5A5);
        queue_req(ACT_SPARE_FIRST, 4'd15, 4'd15, TOKEN_FULL);
        queue_req(ACT_SPARE_FIRST + 3'd1, 4'd0, 4'd0, 16'd0);
        queue_req(ACT_SPARE_LAST, 4'd15, 4'd15, TOKEN_FULL);
        queue_req(ACT_FIRE, 4'd0, 4'd1, 16'd0);
        queue_req(ACT_LIST, 4'd0, 4'd0, 16'd0);
        wait_idle();

        run_phase(5'd1, 5'd1, IDLE_NONE, 40, 0);
        run_phase(5'd16, 5'd16, IDLE_SEND, 50, 0);
        run_phase(5'd31, 5'd31, IDLE_RECV, 50, 0);     // counts above max act as max
        run_phase(5'd0, 5'd9, IDLE_BOTH, 40, 0);       // no places: all enabled
        run_phase(5'd9, 5'd0, IDLE_NONE, 30, 0);       // no transitions: lists empty
        run_phase(5'd12, 5'd16, IDLE_NONE, 40, HOLDOFF_CYCLES);
        repeat (3)
            run_phase(5'($urandom_range(31)), 5'($urandom_range(31)),
                      idle_mode_e'($urandom_range(3)), 50, 0);

        if (expected_reports.size() != 0) begin
            $error("%0d expected reports never arrived", expected_reports.size());
            n_err++;
        end
        $display("Covered %0d list and %0d fire requests over 9 count settings;",
                 n_lists, n_fires);
        $display("%0d fires enabled, %0d clipped, %0d reports checked, %0d errors",
                 n_fired, n_clipped, n_reports, n_err);
        if (n_err == 0) begin
            $display("petri_net_fire_engine_top regression: pass");
        end else begin
            $display("petri_net_fire_engine_top regression: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/pnf_pkg.sv
src/pnf_req_if.sv
src/pnf_rsp_if.sv
src/pnf_ctrl.sv
src/pnf_dp.sv
src/petri_net_fire_engine_top.sv
tb/sv/petri_net_fire_engine_top_tb.sv
